FILE: src/gfcd_pkg.sv
package gfcd_pkg;

    localparam int RADIUS     = 8;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 1024;

    localparam int COST_W    = 16;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int GW_W      = $clog2(MAX_WIDTH + 1);
    localparam int GH_W      = $clog2(MAX_HEIGHT + 1);
    localparam int IN_ROW_W  = $clog2(MAX_HEIGHT + RADIUS + 2);
    localparam int LIN_W     = $clog2(MAX_WIDTH * (MAX_HEIGHT + RADIUS + 2));
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int RSO_W  = $clog2(2 * RADIUS + 2);
    localparam int HIST_N = RADIUS + 1;
    localparam int WORD_W = 2 * HIST_N + RSO_W;
    localparam int OCC_N  = 2 * RADIUS + 1;

    localparam int NEIGHBOR_MIN = 3;

    typedef logic [1:0] cls_t;

    localparam cls_t CLS_UNKNOWN  = 2'd0;
    localparam cls_t CLS_OCCUPIED = 2'd1;
    localparam cls_t CLS_FREE     = 2'd2;

    typedef struct packed {
        cls_t top;
        cls_t mid;
        cls_t bot;
    } trip_t;

    typedef struct packed {
        logic [COL_W-1:0] cell_col;
        logic             first_row;
        cls_t             cls;
        logic             emit;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             last;
        logic [OCC_N-1:0] occ_mask;
        logic             left_ok;
        logic             right_ok;
        logic             top_ok;
        logic             bot_ok;
    } step_t;

endpackage

FILE: src/gfcd_col_ram.sv
module gfcd_col_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/gfcd_window.sv
module gfcd_window (
    input  logic                   clk,
    input  logic                   rd_en,
    input  logic [gfcd_pkg::COL_W-1:0] rd_addr,
    input  gfcd_pkg::step_t        step,
    input  logic                   fire,
    output logic                   frontier
);
    import gfcd_pkg::*;

    localparam logic [RSO_W-1:0] RSO_MAX = '1;

    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] wr_word;
    logic [RSO_W-1:0]  old_rso;
    logic [RSO_W-1:0]  new_rso;
    logic              v_flag;
    cls_t              ext [RADIUS+2];
    logic [OCC_N-1:0]  occ_window;
    logic [OCC_N-2:0]  occ_sh_reg;
    trip_t             trip_vec [RADIUS+2];
    trip_t             trip_sh_reg [RADIUS+1];
    trip_t             nb_l;
    trip_t             nb_c;
    trip_t             nb_r;
    cls_t              nb [8];
    logic              occ_near;
    logic [3:0]        free_n;
    logic [3:0]        unk_n;

    function automatic cls_t pick(cls_t k, logic ok);
        return ok ? k : CLS_UNKNOWN;
    endfunction

    gfcd_col_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .clk     (clk),
        .wr_en   (fire),
        .wr_addr (step.cell_col),
        .wr_data (wr_word),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    always_comb
    begin
        old_rso = step.first_row ? RSO_MAX : rd_word[RSO_W-1:0];
        if (step.cls == CLS_OCCUPIED)
        begin
            new_rso = '0;
        end
        else if (old_rso == RSO_MAX)
        begin
            new_rso = RSO_MAX;
        end
        else
        begin
            new_rso = old_rso + 1'b1;
        end
        v_flag = new_rso <= RSO_W'(2 * RADIUS);

        ext[0] = step.cls;
        for (int i = 0; i <= RADIUS; i++)
        begin
            ext[i+1] = rd_word[RSO_W + 2*i +: 2];
        end

        wr_word[RSO_W-1:0] = new_rso;
        for (int i = 0; i <= RADIUS; i++)
        begin
            wr_word[RSO_W + 2*i +: 2] = ext[i];
        end

        trip_vec[0] = '{top: ext[RADIUS+1], mid: ext[RADIUS], bot: ext[RADIUS-1]};
        for (int k = 1; k <= RADIUS + 1; k++)
        begin
            trip_vec[k] = trip_sh_reg[k-1];
        end

        occ_window = {occ_sh_reg, v_flag};
        occ_near   = |(occ_window & step.occ_mask);
    end

    always_comb
    begin
        nb_r = trip_vec[RADIUS-1];
        nb_c = trip_vec[RADIUS];
        nb_l = trip_vec[RADIUS+1];

        nb[0] = pick(nb_l.top, step.left_ok && step.top_ok);
        nb[1] = pick(nb_l.mid, step.left_ok);
        nb[2] = pick(nb_l.bot, step.left_ok && step.bot_ok);
        nb[3] = pick(nb_c.top, step.top_ok);
        nb[4] = pick(nb_c.bot, step.bot_ok);
        nb[5] = pick(nb_r.top, step.right_ok && step.top_ok);
        nb[6] = pick(nb_r.mid, step.right_ok);
        nb[7] = pick(nb_r.bot, step.right_ok && step.bot_ok);

        free_n = '0;
        unk_n  = '0;
        for (int i = 0; i < 8; i++)
        begin
            free_n = free_n + 4'(nb[i] == CLS_FREE);
            unk_n  = unk_n + 4'(nb[i] == CLS_UNKNOWN);
        end

        frontier = (nb_c.mid == CLS_UNKNOWN) && !occ_near &&
                   (free_n >= 4'(NEIGHBOR_MIN)) && (unk_n >= 4'(NEIGHBOR_MIN));
    end

    // advance the column windows once per step
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            occ_sh_reg <= occ_window[OCC_N-2:0];
            for (int k = 0; k <= RADIUS; k++)
            begin
                trip_sh_reg[k] <= trip_vec[k];
            end
        end
    end

endmodule

FILE: src/grid_frontier_cell_detector_top.sv
// Frontier cell detector for an occupancy grid.
// Input channel (in_valid / in_stall): one beat per cell cost in raster order, column
// fastest; opcode marks flush beats that push the tail of the frame out after the last
// cell. A flush before the last cell is dropped; a cell after the last acts as a flush.
// Output channel (out_valid / out_stall): one decision beat (row, column, is_frontier,
// frame_last) per cell, lagging the input by RADIUS rows and RADIUS columns.
// Throughput is one beat per cycle while out_stall lets results drain. A beat that completes
// a decision passes through the step register and then the result register to the output.
// Per column, one RAM word holds a rows-since-occupied count and the recent class history;
// it is read and written once per beat, so the RAM port sets the one-beat-per-cycle rate.
// Configuration: cfg_write_en, cfg_index, cfg_data; writing width or height restarts
// the frame. Write only while the block is idle.
// Reset: frame position goes to zero, valid flags clear and the configuration registers take
// their defaults; no clearing pass, the block takes beats as soon as reset is released.
// When out_stall holds a result, beats that emit no decision still pass; once the step register
// holds one that does, in_stall rises until the result is taken.
module grid_frontier_cell_detector_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [gfcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gfcd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            opcode,
    input  logic [gfcd_pkg::COST_W-1:0]     cost,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [gfcd_pkg::ROW_W-1:0]      row,
    output logic [gfcd_pkg::COL_W-1:0]      column,
    output logic                            is_frontier,
    output logic                            frame_last
);
    import gfcd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OCC_THR     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FREE_THR    = 2'd3;

    localparam logic OP_FLUSH = 1'b1;

    localparam int SPAN_W = GW_W + 1;

    logic [GW_W-1:0]     grid_width_reg;
    logic [GH_W-1:0]     grid_height_reg;
    logic [COST_W-1:0]   occ_thr_reg;
    logic [COST_W-1:0]   free_thr_reg;
    logic [IN_ROW_W-1:0] in_row_reg;
    logic [COL_W-1:0]    in_col_reg;
    logic [LIN_W-1:0]    lin_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic                s1_valid_reg;
    step_t               s1_reg;
    logic                out_valid_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    column_reg;
    logic                frontier_reg;
    logic                last_reg;

    logic [GW_W-1:0]     w_eff;
    logic [GH_W-1:0]     h_eff;
    logic [LIN_W-1:0]    thr;
    logic                in_accept;
    logic                in_grid;
    logic                step_go;
    logic                emit_now;
    logic                out_last;
    logic                col_wrap;
    logic                out_col_wrap;
    logic                size_write;
    cls_t                cls_now;
    logic [SPAN_W-1:0]   c_span;
    step_t               step_next;
    logic                fire;
    logic                frontier;

    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            w_eff = GW_W'(1);
        end
        else if (grid_width_reg > GW_W'(MAX_WIDTH))
        begin
            w_eff = GW_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = grid_width_reg;
        end

        if (grid_height_reg == '0)
        begin
            h_eff = GH_W'(1);
        end
        else if (grid_height_reg > GH_W'(MAX_HEIGHT))
        begin
            h_eff = GH_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = grid_height_reg;
        end
    end

    assign thr = LIN_W'(w_eff) * LIN_W'(RADIUS) + LIN_W'(RADIUS);

    assign fire      = s1_valid_reg && (!s1_reg.emit || !out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !fire;
    assign in_accept = in_valid && !in_stall;

    assign in_grid      = IN_ROW_W'(in_row_reg) < IN_ROW_W'(h_eff);
    assign step_go      = in_accept && !(in_grid && (opcode == OP_FLUSH));
    assign emit_now     = lin_reg >= thr;
    assign col_wrap     = GW_W'(in_col_reg) == (w_eff - 1'b1);
    assign out_col_wrap = GW_W'(out_col_reg) == (w_eff - 1'b1);
    assign out_last     = emit_now && out_col_wrap &&
                          (GH_W'(out_row_reg) == (h_eff - 1'b1));
    assign size_write   = cfg_write_en &&
                          ((cfg_index == REG_GRID_WIDTH) || (cfg_index == REG_GRID_HEIGHT));

    always_comb
    begin
        if (!in_grid || (cost == '0))
        begin
            cls_now = CLS_UNKNOWN;
        end
        else if (cost <= occ_thr_reg)
        begin
            cls_now = CLS_OCCUPIED;
        end
        else if (cost >= free_thr_reg)
        begin
            cls_now = CLS_FREE;
        end
        else
        begin
            cls_now = CLS_UNKNOWN;
        end
    end

    always_comb
    begin
        c_span = SPAN_W'(out_col_reg) + SPAN_W'(RADIUS);

        step_next.cell_col  = in_col_reg;
        step_next.first_row = in_row_reg == '0;
        step_next.cls       = cls_now;
        step_next.emit      = emit_now;
        step_next.row       = out_row_reg;
        step_next.column    = out_col_reg;
        step_next.last      = out_last;
        for (int j = 0; j < OCC_N; j++)
        begin
            step_next.occ_mask[j] = (c_span >= SPAN_W'(j)) &&
                                    (c_span < (SPAN_W'(w_eff) + SPAN_W'(j)));
        end
        step_next.left_ok  = out_col_reg != '0;
        step_next.right_ok = (GW_W'(out_col_reg) + 1'b1) < w_eff;
        step_next.top_ok   = out_row_reg != '0;
        step_next.bot_ok   = (GH_W'(out_row_reg) + 1'b1) < h_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GW_W'(256);
            grid_height_reg <= GH_W'(256);
            occ_thr_reg     <= COST_W'(16383);
            free_thr_reg    <= COST_W'(16385);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GW_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[GH_W-1:0];
                REG_OCC_THR:     occ_thr_reg     <= cfg_data[COST_W-1:0];
                REG_FREE_THR:    free_thr_reg    <= cfg_data[COST_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            lin_reg     <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end
        else if (size_write || (step_go && out_last))
        begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            lin_reg     <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end
        else if (step_go)
        begin
            lin_reg <= lin_reg + 1'b1;
            if (col_wrap)
            begin
                in_col_reg <= '0;
                in_row_reg <= in_row_reg + 1'b1;
            end
            else
            begin
                in_col_reg <= in_col_reg + 1'b1;
            end
            if (emit_now)
            begin
                if (out_col_wrap)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_reg <= out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (step_go)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go)
        begin
            s1_reg <= step_next;
        end
    end

    gfcd_window u_window (
        .clk      (clk),
        .rd_en    (step_go),
        .rd_addr  (in_col_reg),
        .step     (s1_reg),
        .fire     (fire),
        .frontier (frontier)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && s1_reg.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && s1_reg.emit)
        begin
            row_reg      <= s1_reg.row;
            column_reg   <= s1_reg.column;
            frontier_reg <= frontier;
            last_reg     <= s1_reg.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign row         = row_reg;
    assign column      = column_reg;
    assign is_frontier = frontier_reg;
    assign frame_last  = last_reg;

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (GW_W'(out_col_reg) < w_eff) && (GW_W'(in_col_reg) < w_eff) &&
        (GH_W'(out_row_reg) < h_eff))
        else $error("frame position outside the grid");

    a_restart_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && out_last) |=>
        (lin_reg == '0) && (in_row_reg == '0) && (out_row_reg == '0) && (out_col_reg == '0))
        else $error("frame did not restart after its last decision");

    a_drop_holds_position: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !step_go && !cfg_write_en) |=> $stable(lin_reg) && $stable(in_col_reg))
        else $error("dropped flush beat moved the input position");

    a_no_decision_before_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && !emit_now) |-> (out_row_reg == '0) && (out_col_reg == '0))
        else $error("output position moved before the window filled");

endmodule
